// ===== sv/wsht_pkg.sv =====
// Shared types and constants for the window stack hit test unit.
`timescale 1ns / 1ps
`default_nettype none
package wsht_pkg;

    localparam int MAX_WINDOWS  = 16;
    localparam int COORD_BITS   = 12;
    localparam int CNT_BITS     = $clog2(MAX_WINDOWS + 1);
    localparam int NUM_OUT_BITS = 5;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_CLICK = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CNT_BITS-1:0]   t_count;

    typedef struct packed {
        t_coord left;
        t_coord bottom;
        t_coord right;
        t_coord top;
        t_count num;
    } t_win;

    typedef struct packed {
        logic cap;
        logic raise;
        logic wr;
        logic is_top;
        logic occ;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_RAISE
    } t_state;

endpackage
`default_nettype wire

// ===== sv/window_stack_hit_test_unit.sv =====
// Window stack hit test unit: z-ordered slot chain with move-to-front on click.
// Load: accepted back to back, no result.
// Click: accepted, tested in every slot at once into the hit registers, then raised
// and reported from the raise step into the output register; no new item is accepted until the raise is done.
// The raise step waits while the output register is still full.
// Synchronous active-low reset empties the stack and clears all handshake state.
`timescale 1ns / 1ps
`default_nettype none
module window_stack_hit_test_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_mode,
    input  wire wsht_pkg::t_coord       i_left_x,
    input  wire wsht_pkg::t_coord       i_bottom_y,
    input  wire wsht_pkg::t_coord       i_right_x,
    input  wire wsht_pkg::t_coord       i_top_y,
    input  wire wsht_pkg::t_coord       i_point_x,
    input  wire wsht_pkg::t_coord       i_point_y,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_hit,
    output logic [wsht_pkg::NUM_OUT_BITS-1:0] o_window_number
);
    import wsht_pkg::*;

    t_state r_state;
    t_state n_state;
    t_count r_count;
    t_count n_count;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_out_hit;
    logic   n_out_hit;
    logic [NUM_OUT_BITS-1:0] r_out_num;
    logic [NUM_OUT_BITS-1:0] n_out_num;

    logic w_cap;
    logic w_wr;
    logic w_finish;
    logic w_raise;
    logic w_any;
    logic [31:0] w_num_ext;
    t_win w_load_win;
    t_win w_held;

    logic [MAX_WINDOWS:0]   w_above;
    logic [MAX_WINDOWS:0]   w_le;
    logic [MAX_WINDOWS-1:0] w_sel;
    t_win                   w_win [MAX_WINDOWS];

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_window_number = r_out_num;

    assign w_above[MAX_WINDOWS] = 1'b0;
    assign w_le[0]              = 1'b0;
    assign w_any                = w_above[0];
    assign w_raise              = w_finish & w_any;

    assign w_load_win.left   = i_left_x;
    assign w_load_win.bottom = i_bottom_y;
    assign w_load_win.right  = i_right_x;
    assign w_load_win.top    = i_top_y;
    assign w_load_win.num    = r_count + t_count'(1);

    always_comb begin
        w_held = '0;
        for (int k = 0; k < MAX_WINDOWS; k++) begin
            w_held = w_held | (w_win[k] & {$bits(t_win){w_sel[k]}});
        end
    end

    assign w_num_ext = 32'(w_held.num);

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOWS; g++) begin : g_cell
            t_cell_ctl w_ctl;
            t_win      w_up;

            assign w_ctl.cap    = w_cap;
            assign w_ctl.raise  = w_raise;
            assign w_ctl.wr     = w_wr && (r_count == t_count'(g));
            assign w_ctl.is_top = (r_count == t_count'(g + 1));
            assign w_ctl.occ    = (t_count'(g) < r_count);

            if (g == MAX_WINDOWS - 1) begin : g_top
                assign w_up = w_held;
            end else begin : g_mid
                assign w_up = w_win[g + 1];
            end

            wsht_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_point_x  (i_point_x),
                .i_point_y  (i_point_y),
                .i_load_win (w_load_win),
                .i_up_win   (w_up),
                .i_held_win (w_held),
                .i_above    (w_above[g + 1]),
                .i_le       (w_le[g]),
                .o_above    (w_above[g]),
                .o_le       (w_le[g + 1]),
                .o_sel      (w_sel[g]),
                .o_win      (w_win[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_num   = r_out_num;
        o_ready     = 1'b0;
        w_cap       = 1'b0;
        w_wr        = 1'b0;
        w_finish    = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_mode == MODE_CLICK)) begin
                    w_cap   = 1'b1;
                    n_state = ST_RAISE;
                end else if (i_valid && (r_count < t_count'(MAX_WINDOWS))) begin
                    w_wr    = 1'b1;
                    n_count = r_count + t_count'(1);
                end
            end
            ST_RAISE: begin
                if (!r_out_valid || i_ready) begin
                    w_finish    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_hit   = w_any;
                    n_out_num   = w_any ? w_num_ext[NUM_OUT_BITS-1:0] : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit <= n_out_hit;
        r_out_num <= n_out_num;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(MAX_WINDOWS))
        else $error("window count beyond capacity");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one slot selected");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RAISE))
        else $error("result raised outside the raise step");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_num == '0))
        else $error("ignored click carries a window number");

endmodule
`default_nettype wire

// ===== sv/wsht_cell.sv =====
// One stack slot: holds a window, tests the click and shifts on a raise.
`timescale 1ns / 1ps
`default_nettype none
module wsht_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wsht_pkg::t_cell_ctl i_ctl,
    input  wire wsht_pkg::t_coord  i_point_x,
    input  wire wsht_pkg::t_coord  i_point_y,
    input  wire wsht_pkg::t_win    i_load_win,
    input  wire wsht_pkg::t_win    i_up_win,
    input  wire wsht_pkg::t_win    i_held_win,
    input  wire logic              i_above,
    input  wire logic              i_le,
    output logic                   o_above,
    output logic                   o_le,
    output logic                   o_sel,
    output wsht_pkg::t_win         o_win
);
    import wsht_pkg::*;

    t_win r_win;
    t_win n_win;
    logic r_hit;
    logic n_hit;
    logic w_inside;

    assign w_inside = (i_point_x >= r_win.left) && (i_point_x <= r_win.right) &&
                      (i_point_y >= r_win.bottom) && (i_point_y <= r_win.top);

    assign o_sel   = r_hit & ~i_above;
    assign o_above = i_above | r_hit;
    assign o_le    = i_le | o_sel;
    assign o_win   = r_win;

    always_comb begin
        n_hit = i_ctl.cap ? (i_ctl.occ & w_inside) : r_hit;
        priority if (i_ctl.wr) begin
            n_win = i_load_win;
        end else if (i_ctl.raise && i_ctl.is_top) begin
            n_win = i_held_win;
        end else if (i_ctl.raise && o_le && i_ctl.occ) begin
            n_win = i_up_win;
        end else begin
            n_win = r_win;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

endmodule
`default_nettype wire

// ===== bench/window_stack_checker.sv =====
// Checker for the window stack hit test unit: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module window_stack_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic                              i_mode,
    input  wire wsht_pkg::t_coord                  i_left_x,
    input  wire wsht_pkg::t_coord                  i_bottom_y,
    input  wire wsht_pkg::t_coord                  i_right_x,
    input  wire wsht_pkg::t_coord                  i_top_y,
    input  wire wsht_pkg::t_coord                  i_point_x,
    input  wire wsht_pkg::t_coord                  i_point_y,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic                              i_hit,
    input  wire logic [wsht_pkg::NUM_OUT_BITS-1:0] i_window_number,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_hit_count,
    output int                                     o_miss_count
);
    import wsht_pkg::*;

    typedef struct packed {
        logic                    hit;
        logic [NUM_OUT_BITS-1:0] number;
    } t_click_result;

    t_win          z_stack [MAX_WINDOWS];
    int            z_depth = 0;
    t_click_result expected_clicks [$];

    task automatic push_window(input t_coord l, input t_coord b, input t_coord r,
                               input t_coord t);
        if (z_depth < MAX_WINDOWS) begin
            z_stack[z_depth] = '{left: l, bottom: b, right: r, top: t,
                                 num: t_count'(z_depth + 1)};
            z_depth++;
        end
    endtask

    // Top-down search; a hit is moved to the top, windows above it drop by one.
    function automatic t_click_result resolve_click(input t_coord px, input t_coord py);
        t_click_result res;
        t_win          held;
        res = '0;
        for (int pos = z_depth - 1; pos >= 0; pos--) begin
            if (px >= z_stack[pos].left && px <= z_stack[pos].right &&
                py >= z_stack[pos].bottom && py <= z_stack[pos].top) begin
                res.hit    = 1'b1;
                res.number = NUM_OUT_BITS'(z_stack[pos].num);
                held       = z_stack[pos];
                for (int i = pos; i < z_depth - 1; i++)
                    z_stack[i] = z_stack[i + 1];
                z_stack[z_depth - 1] = held;
                break;
            end
        end
        return res;
    endfunction

    task automatic note_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_click_result want;
        if (!i_rst_n) begin
            z_depth = 0;
            expected_clicks.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_clicks.size() == 0) begin
                    note_failure($sformatf("result with nothing expected: hit=%0d number=%0d",
                                           i_hit, i_window_number));
                end else begin
                    want = expected_clicks.pop_front();
                    if (want.hit !== i_hit)
                        note_failure($sformatf("hit mismatch: expected %0d, got %0d",
                                               want.hit, i_hit));
                    if (want.number !== i_window_number)
                        note_failure($sformatf("window_number mismatch: expected %0d, got %0d",
                                               want.number, i_window_number));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == MODE_CLICK) begin
                    want = resolve_click(i_point_x, i_point_y);
                    expected_clicks.push_back(want);
                    if (want.hit)
                        o_hit_count++;
                    else
                        o_miss_count++;
                end else begin
                    push_window(i_left_x, i_bottom_y, i_right_x, i_top_y);
                end
            end
        end
        o_pending = expected_clicks.size();
    end

endmodule

// ===== bench/tb_window_stack_hit_test_unit.sv =====
// Testbench top for the window stack hit test unit: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module tb_window_stack_hit_test_unit;
    import wsht_pkg::*;

    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int ITEM_TARGET = 1850;
    localparam int HOLD_CYCLES = 300;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_valid    = 1'b0;
    logic                    i_mode     = MODE_LOAD;
    t_coord                  i_left_x   = '0;
    t_coord                  i_bottom_y = '0;
    t_coord                  i_right_x  = '0;
    t_coord                  i_top_y    = '0;
    t_coord                  i_point_x  = '0;
    t_coord                  i_point_y  = '0;
    logic                    i_ready    = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic                    o_hit;
    logic [NUM_OUT_BITS-1:0] o_window_number;

    int fail_count, pending, hit_count, miss_count;

    int   send_idle_pct = 13;
    int   recv_idle_pct = 88;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   hold_left     = 0;
    int   items_done    = 0;
    int   loads_refused = 0;
    t_win placed [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    window_stack_hit_test_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_left_x        (i_left_x),
        .i_bottom_y      (i_bottom_y),
        .i_right_x       (i_right_x),
        .i_top_y         (i_top_y),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_window_number (o_window_number)
    );

    window_stack_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_mode          (i_mode),
        .i_left_x        (i_left_x),
        .i_bottom_y      (i_bottom_y),
        .i_right_x       (i_right_x),
        .i_top_y         (i_top_y),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_hit           (o_hit),
        .i_window_number (o_window_number),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_hit_count     (hit_count),
        .o_miss_count    (miss_count)
    );

    // Result side: random stalls, plus a long hold-off when requested.
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic m, input t_coord lx, input t_coord by,
                             input t_coord rx, input t_coord ty,
                             input t_coord px, input t_coord py);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= m;
        i_left_x   <= lx;
        i_bottom_y <= by;
        i_right_x  <= rx;
        i_top_y    <= ty;
        i_point_x  <= px;
        i_point_y  <= py;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_load(input t_win w);
        items_done++;
        if (placed.size() < MAX_WINDOWS) begin
            placed.push_back(w);
        end else begin
            loads_refused++;
        end
        send_item(MODE_LOAD, w.left, w.bottom, w.right, w.top,
                  t_coord'($urandom), t_coord'($urandom));
    endtask

    task automatic send_click(input t_coord px, input t_coord py);
        items_done++;
        send_item(MODE_CLICK, t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_coord'($urandom), px, py);
    endtask

    function automatic t_win make_window(input int l, input int b, input int r, input int t);
        return '{left: t_coord'(l), bottom: t_coord'(b), right: t_coord'(r),
                 top: t_coord'(t), num: '0};
    endfunction

    // Mostly clamped boxes of varied size; some fully random, often inverted.
    function automatic t_win random_window();
        int cx, cy, hw, hh;
        if ($urandom_range(7) == 0)
            return make_window($urandom, $urandom, $urandom, $urandom);
        cx = $urandom_range(COORD_MAX);
        cy = $urandom_range(COORD_MAX);
        hw = $urandom_range(900);
        hh = $urandom_range(900);
        return make_window((cx - hw < 0) ? 0 : cx - hw,
                           (cy - hh < 0) ? 0 : cy - hh,
                           (cx + hw > COORD_MAX) ? COORD_MAX : cx + hw,
                           (cy + hh > COORD_MAX) ? COORD_MAX : cy + hh);
    endfunction

    // Bias clicks onto window edges and just outside them.
    function automatic t_coord near_span(input t_coord lo, input t_coord hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return lo - 1'b1;
            3: return hi + 1'b1;
            default: return (lo <= hi) ? lo + t_coord'($urandom_range(hi - lo))
                                       : t_coord'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_win w;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty stack, corner bounds, inverted boxes, overlap and raise
        send_click(0, 0);
        send_load(make_window(0, 0, 30, 40));
        send_click(0, 0);
        send_click(30, 40);
        send_click(31, 40);
        send_click(30, 41);
        send_load(make_window(200, 0, 100, COORD_MAX));
        send_click(150, 5);
        send_load(make_window(0, 300, COORD_MAX, 200));
        send_click(5, 250);
        send_load(make_window(2048, 2048, COORD_MAX, COORD_MAX));
        send_click(COORD_MAX, COORD_MAX);
        send_click(2048, 2048);
        send_click(COORD_MAX, 0);
        send_load(make_window(2000, 2000, 2100, 2100));
        send_click(2050, 2050);
        send_click(3000, 3000);
        send_click(2050, 2050);
        send_click(2010, 2010);

        while (items_done < ITEM_TARGET) begin
            if (items_done < ITEM_TARGET / 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 88;
            end else if (items_done < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (hold_requests == 0)
                    hold_requests = 1;
            end
            if ((placed.size() < MAX_WINDOWS) ? ($urandom_range(5) == 0)
                                              : ($urandom_range(11) == 0)) begin
                send_load(random_window());
            end else if (placed.size() == 0 || $urandom_range(2) == 0) begin
                send_click(t_coord'($urandom), t_coord'($urandom));
            end else begin
                w = placed[$urandom_range(placed.size() - 1)];
                send_click(near_span(w.left, w.right), near_span(w.bottom, w.top));
            end
        end
        i_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        $display("Covered %0d clicks (%0d hit, %0d missed), %0d windows, %0d full-stack loads.",
                 hit_count + miss_count, hit_count, miss_count, placed.size(), loads_refused);
        $display("Pacing: three idle regimes on each side and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("Timeout: run did not drain");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== window_stack_hit_test_unit.f =====
sv/wsht_pkg.sv
sv/wsht_cell.sv
sv/window_stack_hit_test_unit.sv
bench/window_stack_checker.sv
bench/tb_window_stack_hit_test_unit.sv
